>>> sv/rmts_pkg.sv
// Shared constants, types and sequencer states of the rate-monotonic tick scheduler.
`timescale 1ns / 1ps
package rmts_pkg;

   localparam int MAX_TASKS   = 8;
   localparam int TIME_BITS   = 32;
   localparam int WORK_BITS   = 16;
   localparam int PERIOD_BITS = 16;
   localparam int IDX_BITS    = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
   localparam int CNT_BITS    = $clog2(MAX_TASKS + 1);

   typedef logic [1:0]             op_type;
   typedef logic [2:0]             slot_type;
   typedef logic [15:0]            cost_type;
   typedef logic [PERIOD_BITS-1:0] period_type;
   typedef logic [WORK_BITS-1:0]   work_type;
   typedef logic [TIME_BITS-1:0]   time_type;
   typedef logic [31:0]            tick_time_type;
   typedef logic [IDX_BITS-1:0]    idx_type;
   typedef logic [CNT_BITS-1:0]    cnt_type;

   localparam op_type OP_TICK  = 2'd0;
   localparam op_type OP_LOAD  = 2'd1;
   localparam op_type OP_START = 2'd2;

   typedef struct packed {
      period_type period;
      cost_type   cost;
   } stat_type;

   typedef struct packed {
      work_type work;
      time_type rel;
   } dyn_type;

   typedef enum logic [2:0] {
      ST_CLR_ALL,
      ST_IDLE,
      ST_CLR_DYN,
      ST_WALK,
      ST_FIX
   } state_type;

endpackage

>>> sv/rmts_req_if.sv
// Request channel of the scheduler: valid, ready and one request's fields.
`timescale 1ns / 1ps
interface rmts_req_if;
   logic                  valid;
   logic                  ready;
   rmts_pkg::op_type      op;
   rmts_pkg::slot_type    slot;
   rmts_pkg::cost_type    cost;
   rmts_pkg::period_type  period;

   modport source (output valid, output op, output slot, output cost, output period,
                   input ready);
   modport sink   (input valid, input op, input slot, input cost, input period,
                   output ready);
endinterface

>>> sv/rmts_rsp_if.sv
// Response channel of the scheduler: valid, ready and one tick result.
`timescale 1ns / 1ps
interface rmts_rsp_if;
   logic                    valid;
   logic                    ready;
   rmts_pkg::slot_type      run_slot;
   logic                    idle;
   rmts_pkg::tick_time_type tick_time;

   modport source (output valid, output run_slot, output idle, output tick_time,
                   input ready);
   modport sink   (input valid, input run_slot, input idle, input tick_time,
                   output ready);
endinterface

>>> sv/rmts_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module rmts_ram #(
   parameter int WIDTH     = 8,
   parameter int DEPTH     = 8,
   parameter int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> sv/rate_monotonic_tick_scheduler_unit.sv
// Top level of the rate-monotonic tick scheduler over a table of periodic tasks.
//
// Requests arrive on req_ch (op, slot, cost, period); tick results leave on
// rsp_ch (run_slot, idle, tick_time). Only a tick request yields a response.
// A load request writes one slot's period and cost in its accept cycle.
// A start request clears time at once and sweeps remaining work and next
// arrivals to zero, one slot per cycle, before the next request is taken.
// A tick request walks the task memories one slot per cycle through one read
// port, releasing and ranking each slot, then writes back the chosen task and
// registers the response; no new request is taken before the block is back
// in its idle step, so a tick is through before the next one starts.
// The response register holds its result while rsp_ch.ready is low; loads and
// starts still proceed, and a further tick waits in its write-back step until
// the register frees.
// After reset the block clears both task memories slot by slot with
// req_ch.ready low; then all slots are empty and time is zero.
`timescale 1ns / 1ps
module rate_monotonic_tick_scheduler_unit (
   input  logic clock,
   input  logic reset,
   rmts_req_if.sink   req_ch,
   rmts_rsp_if.source rsp_ch
);

   rmts_pkg::state_type     state_ff, state_in;
   rmts_pkg::cnt_type       cnt_ff, cnt_in;
   logic                    proc_vld_ff, proc_vld_in;
   rmts_pkg::idx_type       proc_idx_ff, proc_idx_in;
   rmts_pkg::time_type      time_ff, time_in;
   logic                    pick_vld_ff, pick_vld_in;
   rmts_pkg::idx_type       pick_idx_ff, pick_idx_in;
   rmts_pkg::period_type    best_ff, best_in;
   rmts_pkg::dyn_type       pick_dyn_ff, pick_dyn_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   rmts_pkg::slot_type      rsp_slot_ff, rsp_slot_in;
   logic                    rsp_idle_ff, rsp_idle_in;
   rmts_pkg::tick_time_type rsp_time_ff, rsp_time_in;

   logic                    req_accept;
   logic                    slot_in_range;
   logic                    cnt_at_end;
   logic                    cnt_at_last;
   logic                    out_free;
   logic                    rel_hit;
   logic                    cand;

   logic                    stat_we;
   rmts_pkg::idx_type       stat_waddr;
   rmts_pkg::stat_type      stat_wdata;
   rmts_pkg::stat_type      stat_rd;
   logic                    dyn_we;
   rmts_pkg::idx_type       dyn_waddr;
   rmts_pkg::dyn_type       dyn_wdata;
   rmts_pkg::dyn_type       dyn_rd;
   rmts_pkg::dyn_type       dyn_new;
   rmts_pkg::idx_type       rd_addr;

   rmts_ram #(
      .WIDTH ($bits(rmts_pkg::stat_type)),
      .DEPTH (rmts_pkg::MAX_TASKS)
   ) u_stat_ram (
      .clock   (clock),
      .wr_en   (stat_we),
      .wr_addr (stat_waddr),
      .wr_data (stat_wdata),
      .rd_addr (rd_addr),
      .rd_data (stat_rd)
   );

   rmts_ram #(
      .WIDTH ($bits(rmts_pkg::dyn_type)),
      .DEPTH (rmts_pkg::MAX_TASKS)
   ) u_dyn_ram (
      .clock   (clock),
      .wr_en   (dyn_we),
      .wr_addr (dyn_waddr),
      .wr_data (dyn_wdata),
      .rd_addr (rd_addr),
      .rd_data (dyn_rd)
   );

   assign req_accept    = req_ch.valid && req_ch.ready;
   assign slot_in_range = 32'(req_ch.slot) < rmts_pkg::MAX_TASKS;
   assign cnt_at_end    = cnt_ff == rmts_pkg::cnt_type'(rmts_pkg::MAX_TASKS);
   assign cnt_at_last   = cnt_ff == rmts_pkg::cnt_type'(rmts_pkg::MAX_TASKS - 1);
   assign out_free      = !rsp_valid_ff || rsp_ch.ready;
   assign rd_addr       = cnt_ff[rmts_pkg::IDX_BITS-1:0];

   // release and rank the slot whose data the memories return this cycle
   always_comb begin
      rel_hit = (stat_rd.period != '0) && (dyn_rd.rel == time_ff);
      dyn_new = dyn_rd;
      if (rel_hit) begin
         dyn_new.work = stat_rd.cost;
         dyn_new.rel  = dyn_rd.rel + rmts_pkg::time_type'(stat_rd.period);
      end
      cand = proc_vld_ff && (stat_rd.period != '0) && (dyn_new.work != '0) &&
             (!pick_vld_ff || (stat_rd.period < best_ff));
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rmts_pkg::ST_CLR_ALL: begin
            if (cnt_at_last) state_in = rmts_pkg::ST_IDLE;
         end
         rmts_pkg::ST_IDLE: begin
            if (req_accept && req_ch.op == rmts_pkg::OP_START) begin
               state_in = rmts_pkg::ST_CLR_DYN;
            end else if (req_accept && req_ch.op == rmts_pkg::OP_TICK) begin
               state_in = rmts_pkg::ST_WALK;
            end
         end
         rmts_pkg::ST_CLR_DYN: begin
            if (cnt_at_last) state_in = rmts_pkg::ST_IDLE;
         end
         rmts_pkg::ST_WALK: begin
            if (cnt_at_end) state_in = rmts_pkg::ST_FIX;
         end
         rmts_pkg::ST_FIX: begin
            if (out_free) state_in = rmts_pkg::ST_IDLE;
         end
         default: state_in = rmts_pkg::ST_CLR_ALL;
      endcase
   end

   always_comb begin
      req_ch.ready = 1'b0;
      stat_we      = 1'b0;
      stat_waddr   = rd_addr;
      stat_wdata   = '0;
      dyn_we       = 1'b0;
      dyn_waddr    = rd_addr;
      dyn_wdata    = '0;
      case (state_ff)
         rmts_pkg::ST_CLR_ALL: begin
            stat_we = 1'b1;
            dyn_we  = 1'b1;
         end
         rmts_pkg::ST_IDLE: begin
            req_ch.ready      = 1'b1;
            stat_we           = req_accept && (req_ch.op == rmts_pkg::OP_LOAD) &&
                                slot_in_range;
            stat_waddr        = rmts_pkg::idx_type'(req_ch.slot);
            stat_wdata.period = req_ch.period;
            stat_wdata.cost   = req_ch.cost;
         end
         rmts_pkg::ST_CLR_DYN: begin
            dyn_we = 1'b1;
         end
         rmts_pkg::ST_WALK: begin
            dyn_we    = proc_vld_ff;
            dyn_waddr = proc_idx_ff;
            dyn_wdata = dyn_new;
         end
         rmts_pkg::ST_FIX: begin
            dyn_we         = pick_vld_ff && out_free;
            dyn_waddr      = pick_idx_ff;
            dyn_wdata.work = pick_dyn_ff.work - 1'b1;
            dyn_wdata.rel  = pick_dyn_ff.rel;
         end
         default: begin
            req_ch.ready = 1'b0;
         end
      endcase
   end

   always_comb begin
      cnt_in       = cnt_ff;
      proc_vld_in  = 1'b0;
      proc_idx_in  = proc_idx_ff;
      time_in      = time_ff;
      pick_vld_in  = pick_vld_ff;
      pick_idx_in  = pick_idx_ff;
      best_in      = best_ff;
      pick_dyn_in  = pick_dyn_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_slot_in  = rsp_slot_ff;
      rsp_idle_in  = rsp_idle_ff;
      rsp_time_in  = rsp_time_ff;
      case (state_ff)
         rmts_pkg::ST_CLR_ALL, rmts_pkg::ST_CLR_DYN: begin
            cnt_in = cnt_at_last ? '0 : cnt_ff + 1'b1;
         end
         rmts_pkg::ST_IDLE: begin
            cnt_in      = '0;
            pick_vld_in = 1'b0;
            if (req_accept && req_ch.op == rmts_pkg::OP_START) time_in = '0;
         end
         rmts_pkg::ST_WALK: begin
            // issue the next read while the previous slot is processed
            proc_vld_in = !cnt_at_end;
            proc_idx_in = rd_addr;
            if (!cnt_at_end) cnt_in = cnt_ff + 1'b1;
            if (cand) begin
               pick_vld_in = 1'b1;
               pick_idx_in = proc_idx_ff;
               best_in     = stat_rd.period;
               pick_dyn_in = dyn_new;
            end
         end
         rmts_pkg::ST_FIX: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_slot_in  = pick_vld_ff ? rmts_pkg::slot_type'(pick_idx_ff) : '0;
               rsp_idle_in  = !pick_vld_ff;
               rsp_time_in  = rmts_pkg::tick_time_type'(time_ff);
               time_in      = time_ff + 1'b1;
            end
         end
         default: begin
            cnt_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rmts_pkg::ST_CLR_ALL;
         cnt_ff       <= '0;
         proc_vld_ff  <= 1'b0;
         time_ff      <= '0;
         pick_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         proc_vld_ff  <= proc_vld_in;
         time_ff      <= time_in;
         pick_vld_ff  <= pick_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      proc_idx_ff <= proc_idx_in;
      pick_idx_ff <= pick_idx_in;
      best_ff     <= best_in;
      pick_dyn_ff <= pick_dyn_in;
      rsp_slot_ff <= rsp_slot_in;
      rsp_idle_ff <= rsp_idle_in;
      rsp_time_ff <= rsp_time_in;
   end

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.run_slot  = rsp_slot_ff;
   assign rsp_ch.idle      = rsp_idle_ff;
   assign rsp_ch.tick_time = rsp_time_ff;

`ifndef NO_ASSERTIONS
   a_rsp_from_fix: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == rmts_pkg::ST_FIX))
      else $error("response raised outside write-back step");

   a_time_step: assert property (@(posedge clock) disable iff (reset)
      (state_ff == rmts_pkg::ST_FIX && out_free) |=>
      (rsp_valid_ff && rsp_time_ff ==
       rmts_pkg::tick_time_type'(rmts_pkg::time_type'(time_ff - 1'b1))))
      else $error("tick time does not match advanced counter");

   a_walk_reads: assert property (@(posedge clock) disable iff (reset)
      (state_ff == rmts_pkg::ST_WALK && !cnt_at_end) |=>
      (proc_vld_ff && proc_idx_ff == $past(rd_addr)))
      else $error("walk lost a slot read");
`endif

endmodule
